// File: sv/jpt_pkg.sv
package jpt_pkg;

    localparam int unsigned NumChannels = 6;
    localparam int unsigned SumWidth    = 6;
    localparam int unsigned HighShift   = 6;
    localparam int unsigned TowerShift  = 12;
    localparam int unsigned TowerWidth  = 4;
    localparam int unsigned PatchWidth  = 9;
    localparam int unsigned LevelWidth  = 2;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgWidth    = 9;
    localparam int unsigned SelWidth    = 2;

    localparam logic [SumWidth-1:0] PartialMax = 6'd63;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] RegThresholdLow  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] RegThresholdMid  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] RegThresholdHigh = 2'd2;
    localparam logic [CfgIdxWidth-1:0] RegTowerSelect   = 2'd3;

    typedef struct packed {
        logic [15:0] channel_a;
        logic [15:0] channel_b;
        logic [15:0] channel_c;
        logic [15:0] channel_d;
        logic [15:0] channel_e;
        logic [15:0] channel_f;
    } t_in_item;

    typedef struct packed {
        logic [LevelWidth-1:0]  east_level;
        logic [LevelWidth-1:0]  middle_level;
        logic [LevelWidth-1:0]  west_level;
        logic [SumWidth-1:0]    partial_sum;
        logic [TowerWidth-1:0]  tower_bits;
        logic [NumChannels-1:0] channel_tower_flags;
        logic [PatchWidth-1:0]  east_sum;
        logic [PatchWidth-1:0]  middle_sum;
        logic [PatchWidth-1:0]  west_sum;
    } t_out_item;

    // Finished sums handed from the adder stages to the threshold stage.
    typedef struct packed {
        logic [PatchWidth-1:0]  east;
        logic [PatchWidth-1:0]  middle;
        logic [PatchWidth-1:0]  west;
        logic [SumWidth-1:0]    partial;
        logic [TowerWidth-1:0]  towers;
        logic [NumChannels-1:0] flags;
    } t_sum_item;

    typedef struct packed {
        logic [PatchWidth-1:0] thr_low;
        logic [PatchWidth-1:0] thr_mid;
        logic [PatchWidth-1:0] thr_high;
    } t_thresholds;

endpackage

// File: sv/jpt_sum_stage.sv
module jpt_sum_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  jpt_pkg::t_in_item                i_item,
    input  logic [jpt_pkg::SelWidth-1:0]     i_sel,
    output logic                             o_valid,
    output jpt_pkg::t_sum_item               o_sum
);

    logic [15:0] w_word [jpt_pkg::NumChannels];
    logic [5:0]  w_lo   [jpt_pkg::NumChannels];
    logic [5:0]  w_hi   [jpt_pkg::NumChannels];
    logic [3:0]  w_ht   [jpt_pkg::NumChannels];

    // First stage: per-channel and pairwise sums.
    logic [6:0]  r_full [jpt_pkg::NumChannels];
    logic [6:0]  r_mid  [3];
    logic [6:0]  r_podd;
    logic [5:0]  r_hi5;
    logic [3:0]  r_tow;
    logic [5:0]  r_flg;
    logic        r_v1;

    logic [3:0]  n_tow;
    logic [5:0]  n_flg;

    // Second stage: finished sums.
    jpt_pkg::t_sum_item r_sum;
    logic               r_v2;
    logic [7:0]         n_partial;

    assign w_word[0] = i_item.channel_a;
    assign w_word[1] = i_item.channel_b;
    assign w_word[2] = i_item.channel_c;
    assign w_word[3] = i_item.channel_d;
    assign w_word[4] = i_item.channel_e;
    assign w_word[5] = i_item.channel_f;

    always_comb begin
        n_tow = '0;
        n_flg = '0;
        for (int ch = 0; ch < jpt_pkg::NumChannels; ch++) begin
            w_lo[ch] = w_word[ch][jpt_pkg::SumWidth-1:0];
            w_hi[ch] = w_word[ch][jpt_pkg::HighShift +: jpt_pkg::SumWidth];
            w_ht[ch] = w_word[ch][jpt_pkg::TowerShift +: jpt_pkg::TowerWidth];
            n_tow    = n_tow | w_ht[ch];
            n_flg[ch] = w_ht[ch][i_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < jpt_pkg::NumChannels; ch++) begin
            r_full[ch] <= {1'b0, w_lo[ch]} + {1'b0, w_hi[ch]};
        end
        for (int p = 0; p < 3; p++) begin
            r_mid[p] <= {1'b0, w_lo[2*p]} + {1'b0, w_lo[2*p+1]};
        end
        r_podd <= {1'b0, w_hi[1]} + {1'b0, w_hi[3]};
        r_hi5  <= w_hi[5];
        r_tow  <= n_tow;
        r_flg  <= n_flg;
    end

    assign n_partial = {1'b0, r_podd} + {2'b00, r_hi5};

    always_ff @(posedge i_clk) begin
        r_sum.east    <= {2'b00, r_full[0]} + {2'b00, r_full[2]} + {2'b00, r_full[4]};
        r_sum.west    <= {2'b00, r_full[1]} + {2'b00, r_full[3]} + {2'b00, r_full[5]};
        r_sum.middle  <= {2'b00, r_mid[0]} + {2'b00, r_mid[1]} + {2'b00, r_mid[2]};
        r_sum.partial <= (n_partial > {2'b00, jpt_pkg::PartialMax}) ? jpt_pkg::PartialMax
                                                                    : n_partial[5:0];
        r_sum.towers  <= r_tow;
        r_sum.flags   <= r_flg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;

    // The second stage's valid bit follows the first in the next cycle.
    a_valid_travel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 == $past(r_v1))
        else $error("sum pipeline valid bit lost or repeated");

    // Three channels of at most 126 each cannot exceed 378.
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_sum.east <= 9'd378 && r_sum.west <= 9'd378 && r_sum.middle <= 9'd378))
        else $error("jet patch sum out of range");

    // A selected tower bit can only be set when some tower bit is set.
    a_flags_towers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_sum.flags != '0) |-> r_sum.towers != '0)
        else $error("channel flag set without any tower bit");

endmodule

// File: sv/jpt_level_stage.sv
module jpt_level_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  jpt_pkg::t_sum_item    i_sum,
    input  jpt_pkg::t_thresholds  i_thr,
    output logic                  o_done,
    output jpt_pkg::t_out_item    o_result
);

    function automatic logic [jpt_pkg::LevelWidth-1:0] level_of(
        input logic [jpt_pkg::PatchWidth-1:0] sum,
        input jpt_pkg::t_thresholds           thr
    );
        logic [jpt_pkg::LevelWidth-1:0] n;
        n = {1'b0, sum > thr.thr_low} + {1'b0, sum > thr.thr_mid}
          + {1'b0, sum > thr.thr_high};
        return n;
    endfunction

    jpt_pkg::t_out_item r_result;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        r_result.east_level          <= level_of(i_sum.east, i_thr);
        r_result.middle_level        <= level_of(i_sum.middle, i_thr);
        r_result.west_level          <= level_of(i_sum.west, i_thr);
        r_result.partial_sum         <= i_sum.partial;
        r_result.tower_bits          <= i_sum.towers;
        r_result.channel_tower_flags <= i_sum.flags;
        r_result.east_sum            <= i_sum.east;
        r_result.middle_sum          <= i_sum.middle;
        r_result.west_sum            <= i_sum.west;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: sv/jet_patch_threshold_trigger.sv
// Jet patch threshold trigger.
//
// Input channel: drive six channel words on i_item and raise i_start for one
// cycle per item. o_busy is always low, so an item is taken on every clock
// edge at which i_start is high; a new item may follow in every cycle.
// Output channel: o_done pulses for exactly one cycle while o_result holds
// the levels, sums and tower flags of one item. The receiver cannot hold
// results off, and results come out in the order the items went in.
// Throughput is one item per cycle. Each item passes through the three
// register stages in order: channel pair sums, patch sums with saturation
// of the partial sum, and the threshold compares with the output register.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx on the
// clock edge (0..2 are the three thresholds, 3 the tower bit select). The
// thresholds are sampled in the last stage and the select in the first, so
// write them only while no item is in flight.
// Reset (i_rst_n low, synchronous) clears all thresholds and the select to
// zero and drops every item still in the pipeline.
module jet_patch_threshold_trigger (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  jpt_pkg::t_in_item                   i_item,
    output logic                                o_done,
    output jpt_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [jpt_pkg::CfgIdxWidth-1:0]     i_cfg_idx,
    input  logic [jpt_pkg::CfgWidth-1:0]        i_cfg_data
);

    jpt_pkg::t_thresholds             r_thr;
    logic [jpt_pkg::SelWidth-1:0]     r_sel;

    logic                             w_sum_valid;
    jpt_pkg::t_sum_item               w_sum;

    // Configuration registers; the index covers exactly the four registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_sel <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jpt_pkg::RegThresholdLow:  r_thr.thr_low  <= i_cfg_data;
                jpt_pkg::RegThresholdMid:  r_thr.thr_mid  <= i_cfg_data;
                jpt_pkg::RegThresholdHigh: r_thr.thr_high <= i_cfg_data;
                jpt_pkg::RegTowerSelect:   r_sel <= i_cfg_data[jpt_pkg::SelWidth-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so it is always ready for the next item.
    assign o_busy = 1'b0;

    jpt_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_item  (i_item),
        .i_sel   (r_sel),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum)
    );

    jpt_level_stage u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sum_valid),
        .i_sum    (w_sum),
        .i_thr    (r_thr),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// File: bench/jet_patch_threshold_trigger_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the jet patch threshold trigger. A scoreboard
// predicts the levels, sums and tower flags of every accepted item and checks
// each result strobe against the oldest prediction, field by field.
module jet_patch_threshold_trigger_tb;

    import jpt_pkg::*;

    // Three register stages from the accepting edge to the result edge.
    localparam int Latency = 3;
    // The longest legal quiet stretch is far shorter, so this is generous.
    localparam int WatchdogLimit = 1000;
    // Largest value any jet patch sum can reach (three channels of 63 + 63).
    localparam int MaxPatchSum = 378;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    logic      o_busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;
    logic                   i_cfg_we;
    logic [CfgIdxWidth-1:0] i_cfg_idx;
    logic [CfgWidth-1:0]    i_cfg_data;

    jet_patch_threshold_trigger u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // The scoreboard keeps its own copy of the four registers, since the
    // block has no read-back, and a queue of the results still to come.
    class trigger_scoreboard;
        logic [PatchWidth-1:0] thr_low;
        logic [PatchWidth-1:0] thr_mid;
        logic [PatchWidth-1:0] thr_high;
        logic [SelWidth-1:0]   tower_sel;
        t_out_item             awaited[$];
        int                    errors;

        function new();
            thr_low   = '0;
            thr_mid   = '0;
            thr_high  = '0;
            tower_sel = '0;
            errors    = 0;
        endfunction

        function void set_register(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data);
            case (idx)
                RegThresholdLow:  thr_low   = data[PatchWidth-1:0];
                RegThresholdMid:  thr_mid   = data[PatchWidth-1:0];
                RegThresholdHigh: thr_high  = data[PatchWidth-1:0];
                RegTowerSelect:   tower_sel = data[SelWidth-1:0];
                default: ;
            endcase
        endfunction

        function logic [LevelWidth-1:0] patch_level(logic [PatchWidth-1:0] sum);
            int count;
            count = 0;
            if (sum > thr_low)  count++;
            if (sum > thr_mid)  count++;
            if (sum > thr_high) count++;
            return LevelWidth'(count);
        endfunction

        function t_out_item trigger_outcome(t_in_item it);
            logic [15:0]            words [NumChannels];
            logic [SumWidth-1:0]    lo;
            logic [SumWidth-1:0]    hi;
            logic [TowerWidth-1:0]  ht;
            logic [PatchWidth-1:0]  east;
            logic [PatchWidth-1:0]  middle;
            logic [PatchWidth-1:0]  west;
            logic [7:0]             odd_high;
            logic [TowerWidth-1:0]  towers;
            logic [NumChannels-1:0] flags;
            t_out_item              r;
            words = '{it.channel_a, it.channel_b, it.channel_c,
                      it.channel_d, it.channel_e, it.channel_f};
            east     = '0;
            middle   = '0;
            west     = '0;
            odd_high = '0;
            towers   = '0;
            flags    = '0;
            for (int n = 0; n < NumChannels; n++) begin
                lo = words[n][SumWidth-1:0];
                hi = words[n][HighShift +: SumWidth];
                ht = words[n][TowerShift +: TowerWidth];
                middle = middle + lo;
                if (n % 2 == 0) begin
                    east = east + lo + hi;
                end else begin
                    west     = west + lo + hi;
                    odd_high = odd_high + hi;
                end
                towers   = towers | ht;
                flags[n] = ht[tower_sel];
            end
            r.east_level          = patch_level(east);
            r.middle_level        = patch_level(middle);
            r.west_level          = patch_level(west);
            r.partial_sum         = (odd_high > 8'd63) ? 6'd63 : odd_high[SumWidth-1:0];
            r.tower_bits          = towers;
            r.channel_tower_flags = flags;
            r.east_sum            = east;
            r.middle_sum          = middle;
            r.west_sum            = west;
            return r;
        endfunction

        function void note_item(t_in_item it);
            awaited.push_back(trigger_outcome(it));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with no item outstanding, expected none, actual %h",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("east_level",          want.east_level,          got.east_level);
            compare_field("middle_level",        want.middle_level,        got.middle_level);
            compare_field("west_level",          want.west_level,          got.west_level);
            compare_field("partial_sum",         want.partial_sum,         got.partial_sum);
            compare_field("tower_bits",          want.tower_bits,          got.tower_bits);
            compare_field("channel_tower_flags", want.channel_tower_flags,
                          got.channel_tower_flags);
            compare_field("east_sum",            want.east_sum,            got.east_sum);
            compare_field("middle_sum",          want.middle_sum,          got.middle_sum);
            compare_field("west_sum",            want.west_sum,            got.west_sum);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    trigger_scoreboard sb;
    int quiet_cycles;

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Everything the bench sees is sampled on the rising edge. Inputs are
    // only ever changed on the falling edge, and the block updates its
    // outputs with the rising edge, so the values read here are the ones the
    // block itself saw. Register writes are mirrored into the scoreboard at
    // the edge that commits them. The watchdog counts edges at which neither
    // an item nor a result moved.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (i_cfg_we) sb.set_register(i_cfg_idx, i_cfg_data);
            if (i_start && !o_busy) sb.note_item(i_item);
            if (o_done) sb.check_result(o_result);
            if ((i_start && !o_busy) || o_done) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WatchdogLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic t_in_item pack_channels(logic [15:0] w [NumChannels]);
        t_in_item it;
        it.channel_a = w[0];
        it.channel_b = w[1];
        it.channel_c = w[2];
        it.channel_d = w[3];
        it.channel_e = w[4];
        it.channel_f = w[5];
        return it;
    endfunction

    function automatic logic [15:0] channel_word(int unsigned lo, int unsigned hi,
                                                 int unsigned ht);
        return {4'(ht), 6'(hi), 6'(lo)};
    endfunction

    // Fill six 6-bit sum fields greedily so that they add up to the target.
    function automatic void spread_sum(int unsigned target, output int unsigned f [6]);
        int unsigned rest;
        rest = target;
        for (int k = 0; k < 6; k++) begin
            f[k] = (rest > 63) ? 63 : rest;
            rest = rest - f[k];
        end
    endfunction

    // An item whose east and west patch sums land exactly on chosen values,
    // used to probe each threshold right at and just above its setting.
    function automatic t_in_item patch_item(int unsigned east_target, int unsigned west_target);
        int unsigned ef [6];
        int unsigned wf [6];
        logic [15:0] w [NumChannels];
        spread_sum(east_target, ef);
        spread_sum(west_target, wf);
        for (int k = 0; k < 3; k++) begin
            w[2*k]   = channel_word(ef[2*k], ef[2*k+1], $urandom_range(0, 15));
            w[2*k+1] = channel_word(wf[2*k], wf[2*k+1], $urandom_range(0, 15));
        end
        return pack_channels(w);
    endfunction

    // Random items come in several flavors: half raw words, which reach
    // every bit, plus items skewed toward large, small or extreme sums so
    // that all levels and the partial saturation show up often.
    function automatic t_in_item random_item();
        logic [15:0] w [NumChannels];
        int flavor;
        flavor = $urandom_range(0, 9);
        for (int n = 0; n < NumChannels; n++) begin
            case (flavor)
                0, 1, 2, 3, 4: w[n] = 16'($urandom);
                5: w[n] = channel_word($urandom_range(40, 63), $urandom_range(40, 63),
                                       $urandom_range(0, 15));
                6: w[n] = channel_word($urandom_range(0, 7), $urandom_range(0, 7),
                                       $urandom_range(0, 15));
                7: w[n] = channel_word($urandom_range(0, 1) * 63, $urandom_range(0, 1) * 63,
                                       $urandom_range(0, 1) * 15);
                default: w[n] = 16'($urandom) & 16'hF03F;
            endcase
        end
        return pack_channels(w);
    endfunction

    // Offer one item and return at the edge that takes it. o_busy only moves
    // on a rising edge, so its value at the falling edge holds until the
    // next rising edge. A following call keeps i_start high without a gap.
    task automatic send_item(input t_in_item it);
        logic busy_now;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= it;
        busy_now = o_busy;
        while (busy_now) begin
            @(negedge i_clk);
            busy_now = o_busy;
        end
        @(posedge i_clk);
    endtask

    // Hold i_start low for the given number of cycles with junk on the item
    // bus, which the block has to ignore.
    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        i_start <= 1'b0;
        i_item  <= t_in_item'({$urandom, $urandom, $urandom});
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending, wait for every predicted result, then let the pipeline
    // settle a little longer so that the registers can be rewritten safely.
    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (Latency + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] data);
        @(negedge i_clk);
        i_start    <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic in bursts of random length. About a quarter of the
    // bursts run straight into the next one, the rest leave a gap of random
    // length so that the gaps land on every stage of the pipeline.
    task automatic random_traffic(input int count, input bit mid_drain);
        int sent;
        int burst;
        bit drained;
        sent    = 0;
        drained = 1'b0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            repeat (burst) send_item(random_item());
            sent += burst;
            if (mid_drain && !drained && sent >= count / 2) begin
                drain_results();
                drained = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 8));
            end
        end
    endtask

    // One configuration setting: program all four registers while the
    // block is idle, probe the thresholds at their edges, then run random
    // traffic and wait for it to finish.
    task automatic run_setting(input int unsigned low, input int unsigned mid,
                               input int unsigned high, input int unsigned sel_data,
                               input int count, input bit mid_drain);
        int unsigned thr [3];
        write_reg(RegThresholdLow,  CfgWidth'(low));
        write_reg(RegThresholdMid,  CfgWidth'(mid));
        write_reg(RegThresholdHigh, CfgWidth'(high));
        write_reg(RegTowerSelect,   CfgWidth'(sel_data));
        thr = '{low, mid, high};
        foreach (thr[k]) begin
            if (thr[k] < MaxPatchSum) begin
                send_item(patch_item(thr[k], thr[k] + 1));
                send_item(patch_item(thr[k] + 1, thr[k]));
            end else begin
                send_item(patch_item(MaxPatchSum, MaxPatchSum - 1));
            end
        end
        random_traffic(count, mid_drain);
        drain_results();
    endtask

    initial begin
        logic [15:0] w [NumChannels];
        sb = new();
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset settings (all thresholds zero,
        // tower bit 0 selected): empty and full words, each field alone at
        // its maximum, each tower bit alone, each channel alone at all ones
        // and the partial sum around its saturation point.
        send_item(t_in_item'('0));
        send_item(t_in_item'({6{16'hFFFF}}));
        send_item(t_in_item'({6{16'h003F}}));
        send_item(t_in_item'({6{16'h0FC0}}));
        send_item(t_in_item'({6{16'hF000}}));
        for (int b = 0; b < TowerWidth; b++) begin
            send_item(t_in_item'({6{16'(1 << (TowerShift + b))}}));
        end
        for (int n = 0; n < NumChannels; n++) begin
            foreach (w[k]) w[k] = (k == n) ? 16'hFFFF : 16'h0000;
            send_item(pack_channels(w));
        end
        // Odd channels carrying high-eta sums of 62, 63 and 64 in total.
        foreach (w[k]) w[k] = (k % 2 == 1) ? channel_word(0, 21, 0) : 16'h0000;
        w[5] = channel_word(0, 20, 0);
        send_item(pack_channels(w));
        w[5] = channel_word(0, 21, 0);
        send_item(pack_channels(w));
        w[5] = channel_word(0, 22, 0);
        send_item(pack_channels(w));
        // A single unit in one low-eta field just clears zero thresholds.
        foreach (w[k]) w[k] = 16'h0000;
        w[2] = channel_word(1, 0, 0);
        send_item(pack_channels(w));
        drain_results();

        // Settings in turn: ascending, descending, all at the top, edges of
        // the sum range, then two random ones. The select is also written
        // with data wider than two bits to show that only the low bits count.
        run_setting(100, 200, 300, 1, 60, 1'b0);
        run_setting(300, 200, 100, 2, 60, 1'b1);
        run_setting(511, 511, 511, 9'h1FF, 60, 1'b0);
        run_setting(377, 0, 378, 9'h100, 60, 1'b0);
        run_setting($urandom_range(0, 511), $urandom_range(0, 511),
                    $urandom_range(0, 511), $urandom_range(0, 511), 60, 1'b1);
        run_setting($urandom_range(0, 200), $urandom_range(0, 200),
                    $urandom_range(0, 200), $urandom_range(0, 511), 60, 1'b0);

        // drain_results has already waited out the pipeline; anything still
        // queued would be a lost result.
        if (sb.outstanding() != 0) begin
            sb.errors += sb.outstanding();
            $display("%0t: results never arrived, expected %0d more, actual 0",
                     $time, sb.outstanding());
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/jpt_pkg.sv
sv/jpt_sum_stage.sv
sv/jpt_level_stage.sv
sv/jet_patch_threshold_trigger.sv
bench/jet_patch_threshold_trigger_tb.sv
